FILE: design/pswr_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG stored-deflate writer.
`default_nettype none
package pswr_pkg;

  localparam int DIM_W     = 13;
  localparam int RAW_W     = 28;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cmd_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/png_stored_deflate_writer_top.sv
// Top level of the PNG stored-deflate writer: front end, back end and checks.
`default_nettype none
// The block emits one byte of the PNG file per cycle while the result queue has room;
// a pixel emits four bytes, five at a row start, plus five per stored-deflate block
// header; the last pixel adds twenty bytes for the Adler-32, IDAT CRC and IEND chunk,
// and a start emits 43. The back-end byte sequencer makes them; a four-entry command
// queue takes requests while it works; a two-entry result queue decouples the output.
module png_stored_deflate_writer_top import pswr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 command,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           alpha,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [7:0]                out_byte,
  output logic                      last_of_run,
  output logic                      end_of_image,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  pswr_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  pswr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_eoi_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_image) |-> last_of_run)
    else $error("end of image without last of run");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");

endmodule
`default_nettype wire

FILE: design/pswr_front.sv
// Front end: configuration registers, request classification and the command queue.
`default_nettype none
module pswr_front import pswr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 command,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           alpha,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 cmd_pop,
  output logic                      cmd_valid,
  output cmd_t                      cmd
);

  localparam int CMD_DEPTH = 4;
  localparam int PTR_W     = $clog2(CMD_DEPTH);
  localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  cmd_t             q_mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  cmd_t             entry;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign full      = (count == CNT_W'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    entry.kind   = cmd_kind_t'(command);
    entry.red    = red;
    entry.green  = green;
    entry.blue   = blue;
    entry.alpha  = alpha;
    entry.width  = clamp_dim(image_width);
    entry.height = clamp_dim(image_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(320);
      image_height <= DIM_W'(240);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/pswr_idat_len.sv
// Three-stage pipeline that computes the raw data length and the IDAT chunk length.
`default_nettype none
module pswr_idat_len import pswr_pkg::*; (
  input  wire logic             clk,
  input  wire logic [DIM_W-1:0] width,
  input  wire logic [DIM_W-1:0] height,
  output logic [RAW_W-1:0]      raw_len,
  output logic [31:0]           idat_len
);

  logic [RAW_W:0]   y;
  logic [12:0]      q;
  logic [16:0]      r;
  logic [12:0]      nblocks;
  logic [RAW_W-1:0] raw_len_d;

  always_comb begin
    y = {1'b0, raw_len} + (RAW_W + 1)'(65534);
    q = y[RAW_W:16];
    r = {1'b0, y[15:0]} + {4'b0, q};
  end

  always_ff @(posedge clk) begin
    raw_len   <= RAW_W'({15'b0, height} * ({2'b0, width, 2'b0} + 28'd1));
    nblocks   <= (r >= 17'd65535) ? q + 13'd1 : q;
    raw_len_d <= raw_len;
    idat_len  <= 32'd6 + {4'b0, raw_len_d} + ({19'b0, nblocks} * 32'd5);
  end

endmodule
`default_nettype wire

FILE: design/pswr_back.sv
// Back end: byte sequencer with running CRC-32 and Adler-32, and the result queue.
`default_nettype none
module pswr_back import pswr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            end_of_image
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_PIX, S_TAIL} state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } obyte_t;

  state_t           state;
  logic [5:0]       step;
  logic [2:0]       rix;
  logic [2:0]       hix;
  logic             image_open;
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [15:0]      block_fill;
  logic [RAW_W-1:0] raw_remaining;
  logic [15:0]      adler_low;
  logic [15:0]      adler_high;
  logic [31:0]      chunk_crc;
  logic [DIM_W-1:0] cur_w;
  logic [DIM_W-1:0] cur_h;
  logic [7:0]       px_r, px_g, px_b, px_a;

  logic [RAW_W-1:0] raw_len;
  logic [31:0]      idat_len;

  obyte_t           o_mem [2];
  logic             o_wr;
  logic             o_rd;
  logic [1:0]       o_cnt;
  logic             o_pop;
  logic             space;
  logic             adv;

  obyte_t           gen;
  logic             in_crc;
  logic             fin;
  logic             crc_clear;
  logic             load;
  logic             open_eff;
  logic [31:0]      crc_inv;
  logic [2:0]       erix;
  logic             need_hdr;
  logic [15:0]      len16;
  logic [7:0]       raw_b;
  logic [DIM_W:0]   col_inc;
  logic             wrap;
  logic [DIM_W:0]   row_inc;
  logic             done;
  logic [16:0]      low_sum;
  logic [15:0]      low_n;
  logic [16:0]      high_sum;
  logic [15:0]      high_n;
  logic [15:0]      fill_inc;

  pswr_idat_len u_len (
    .clk      (clk),
    .width    (cur_w),
    .height   (cur_h),
    .raw_len  (raw_len),
    .idat_len (idat_len)
  );

  assign o_pop        = pop && (o_cnt != 2'd0);
  assign empty        = (o_cnt == 2'd0);
  assign out_byte     = o_mem[o_rd].data;
  assign last_of_run  = o_mem[o_rd].last;
  assign end_of_image = o_mem[o_rd].eoi;
  assign space        = (o_cnt != 2'd2) || o_pop;
  assign adv          = (state != S_IDLE) && space;
  assign crc_inv      = ~chunk_crc;

  always_comb begin
    erix     = ((rix == 3'd0) && (column_count != '0)) ? 3'd1 : rix;
    need_hdr = (block_fill == 16'd0) && (hix != 3'd5);
    len16    = (raw_remaining > RAW_W'(65535)) ? BLOCK_MAX : raw_remaining[15:0];
    case (erix)
      3'd1:    raw_b = px_r;
      3'd2:    raw_b = px_g;
      3'd3:    raw_b = px_b;
      3'd4:    raw_b = px_a;
      default: raw_b = 8'd0;
    endcase
    col_inc  = {1'b0, column_count} + (DIM_W + 1)'(1);
    wrap     = col_inc >= {1'b0, cur_w};
    row_inc  = {1'b0, row_count} + {{DIM_W{1'b0}}, wrap};
    done     = row_inc >= {1'b0, cur_h};
    low_sum  = {1'b0, adler_low} + {9'b0, raw_b};
    low_n    = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
    high_sum = {1'b0, adler_high} + {1'b0, low_n};
    high_n   = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
    fill_inc = (block_fill == 16'hFFFE) ? 16'd0 : block_fill + 16'd1;
  end

  always_comb begin
    gen       = '0;
    in_crc    = 1'b0;
    fin       = 1'b0;
    crc_clear = 1'b0;
    case (state)
      S_START: begin
        case (step)
          6'd0:  gen.data = 8'h89;
          6'd1:  gen.data = 8'h50;
          6'd2:  gen.data = 8'h4E;
          6'd3:  gen.data = 8'h47;
          6'd4:  gen.data = 8'h0D;
          6'd5:  gen.data = 8'h0A;
          6'd6:  gen.data = 8'h1A;
          6'd7:  gen.data = 8'h0A;
          6'd11: gen.data = 8'd13;
          6'd12: gen.data = "I";
          6'd13: gen.data = "H";
          6'd14: gen.data = "D";
          6'd15: gen.data = "R";
          6'd18: gen.data = {3'b0, cur_w[12:8]};
          6'd19: gen.data = cur_w[7:0];
          6'd22: gen.data = {3'b0, cur_h[12:8]};
          6'd23: gen.data = cur_h[7:0];
          6'd24: gen.data = 8'd8;
          6'd25: gen.data = 8'd6;
          6'd29: gen.data = crc_inv[31:24];
          6'd30: gen.data = crc_inv[23:16];
          6'd31: gen.data = crc_inv[15:8];
          6'd32: gen.data = crc_inv[7:0];
          6'd33: gen.data = idat_len[31:24];
          6'd34: gen.data = idat_len[23:16];
          6'd35: gen.data = idat_len[15:8];
          6'd36: gen.data = idat_len[7:0];
          6'd37: gen.data = "I";
          6'd38: gen.data = "D";
          6'd39: gen.data = "A";
          6'd40: gen.data = "T";
          6'd41: gen.data = 8'h78;
          6'd42: gen.data = 8'h01;
          default: gen.data = 8'd0;
        endcase
        in_crc    = ((step >= 6'd12) && (step <= 6'd28)) || (step >= 6'd37);
        crc_clear = (step == 6'd0) || (step == 6'd32);
        fin       = (step == 6'd42);
        gen.last  = fin;
      end
      S_PIX: begin
        in_crc = 1'b1;
        if (need_hdr) begin
          case (hix)
            3'd0:    gen.data = {7'b0, raw_remaining <= RAW_W'(65535)};
            3'd1:    gen.data = len16[7:0];
            3'd2:    gen.data = len16[15:8];
            3'd3:    gen.data = ~len16[7:0];
            3'd4:    gen.data = ~len16[15:8];
            default: gen.data = 8'd0;
          endcase
        end else begin
          gen.data = raw_b;
          fin      = (erix == 3'd4) && !done;
          gen.last = fin;
        end
      end
      S_TAIL: begin
        case (step)
          6'd0:  gen.data = adler_high[15:8];
          6'd1:  gen.data = adler_high[7:0];
          6'd2:  gen.data = adler_low[15:8];
          6'd3:  gen.data = adler_low[7:0];
          6'd4:  gen.data = crc_inv[31:24];
          6'd5:  gen.data = crc_inv[23:16];
          6'd6:  gen.data = crc_inv[15:8];
          6'd7:  gen.data = crc_inv[7:0];
          6'd12: gen.data = "I";
          6'd13: gen.data = "E";
          6'd14: gen.data = "N";
          6'd15: gen.data = "D";
          6'd16: gen.data = crc_inv[31:24];
          6'd17: gen.data = crc_inv[23:16];
          6'd18: gen.data = crc_inv[15:8];
          6'd19: gen.data = crc_inv[7:0];
          default: gen.data = 8'd0;
        endcase
        in_crc    = (step <= 6'd3) || ((step >= 6'd12) && (step <= 6'd15));
        crc_clear = (step == 6'd7) || (step == 6'd19);
        fin       = (step == 6'd19);
        gen.last  = fin;
        gen.eoi   = fin;
      end
      default: begin
        gen = '0;
      end
    endcase
  end

  always_comb begin
    open_eff = image_open;
    if (adv && fin && (state == S_START)) begin
      open_eff = 1'b1;
    end else if (adv && fin && (state == S_TAIL)) begin
      open_eff = 1'b0;
    end
  end

  assign load    = cmd_valid && ((state == S_IDLE) || (fin && adv));
  assign cmd_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      rix           <= '0;
      hix           <= '0;
      image_open    <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      block_fill    <= '0;
      raw_remaining <= '0;
      adler_low     <= 16'd1;
      adler_high    <= 16'd0;
      chunk_crc     <= CRC_INIT;
      cur_w         <= '0;
      cur_h         <= '0;
    end else begin
      if (adv) begin
        if (crc_clear) begin
          chunk_crc <= CRC_INIT;
        end else if (in_crc) begin
          chunk_crc <= crc_byte(chunk_crc, gen.data);
        end
        step <= step + 6'd1;
        if (fin) begin
          state <= S_IDLE;
        end
        case (state)
          S_START: begin
            if (fin) begin
              image_open    <= 1'b1;
              column_count  <= '0;
              row_count     <= '0;
              block_fill    <= '0;
              raw_remaining <= raw_len;
              adler_low     <= 16'd1;
              adler_high    <= 16'd0;
            end
          end
          S_PIX: begin
            if (need_hdr) begin
              hix <= hix + 3'd1;
            end else begin
              hix        <= '0;
              rix        <= erix + 3'd1;
              adler_low  <= low_n;
              adler_high <= high_n;
              block_fill <= fill_inc;
              if (raw_remaining != '0) begin
                raw_remaining <= raw_remaining - RAW_W'(1);
              end
              if (erix == 3'd4) begin
                column_count <= wrap ? '0 : col_inc[DIM_W-1:0];
                row_count    <= row_inc[DIM_W-1:0];
                if (done) begin
                  state <= S_TAIL;
                  step  <= '0;
                end
              end
            end
          end
          S_TAIL: begin
            if (fin) begin
              image_open    <= 1'b0;
              column_count  <= '0;
              row_count     <= '0;
              block_fill    <= '0;
              raw_remaining <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (load) begin
        step <= '0;
        rix  <= '0;
        hix  <= '0;
        if (cmd.kind == CMD_START) begin
          state <= S_START;
          cur_w <= cmd.width;
          cur_h <= cmd.height;
        end else if (open_eff) begin
          state <= S_PIX;
          px_r  <= cmd.red;
          px_g  <= cmd.green;
          px_b  <= cmd.blue;
          px_a  <= cmd.alpha;
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mem[o_wr] <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= 1'b0;
      o_rd  <= 1'b0;
      o_cnt <= 2'd0;
    end else begin
      if (adv) begin
        o_wr <= ~o_wr;
      end
      if (o_pop) begin
        o_rd <= ~o_rd;
      end
      if (adv && !o_pop) begin
        o_cnt <= o_cnt + 2'd1;
      end else if (o_pop && !adv) begin
        o_cnt <= o_cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_png_stored_deflate_writer_top.sv
// Testbench for the PNG stored-deflate writer: random and directed images checked byte by byte.
`default_nettype none

class png_byte_scoreboard;
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } png_byte_t;

  png_byte_t   expected_bytes[$];
  png_byte_t   run_bytes[$];
  int          errors;
  int          images_done;
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  bit          open;
  int          col;
  int          row;
  int          fill;
  longint      raw_left;
  int          ad_lo;
  int          ad_hi;
  logic [31:0] crc;
  int          img_w;
  int          img_h;

  function new();
    errors = 0;
    images_done = 0;
    reg_width = 13'd320;
    reg_height = 13'd240;
    open = 0;
    col = 0;
    row = 0;
    fill = 0;
    raw_left = 0;
    ad_lo = 1;
    ad_hi = 0;
    crc = 32'hFFFFFFFF;
    img_w = 0;
    img_h = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [12:0] val);
    if (idx == pswr_pkg::REG_IMAGE_WIDTH) begin
      reg_width = val;
    end else if (idx == pswr_pkg::REG_IMAGE_HEIGHT) begin
      reg_height = val;
    end
  endfunction

  function void put(logic [7:0] b, bit in_crc);
    png_byte_t e;
    if (in_crc) begin
      crc = crc ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? (32'hEDB88320 ^ (crc >> 1)) : (crc >> 1);
      end
    end
    e.data = b;
    e.last = 0;
    e.eoi = 0;
    run_bytes.push_back(e);
  endfunction

  function void put32(logic [31:0] v, bit in_crc);
    put(v[31:24], in_crc);
    put(v[23:16], in_crc);
    put(v[15:8], in_crc);
    put(v[7:0], in_crc);
  endfunction

  function void put_crc();
    put32(~crc, 0);
    crc = 32'hFFFFFFFF;
  endfunction

  function void put_raw(logic [7:0] b);
    int len;
    if (fill == 0) begin
      len = raw_left > 65535 ? 65535 : int'(raw_left);
      put(raw_left <= 65535 ? 8'd1 : 8'd0, 1);
      put(len[7:0], 1);
      put(len[15:8], 1);
      put(~len[7:0], 1);
      put(~len[15:8], 1);
    end
    put(b, 1);
    ad_lo += b;
    if (ad_lo >= 65521) ad_lo -= 65521;
    ad_hi += ad_lo;
    if (ad_hi >= 65521) ad_hi -= 65521;
    if (raw_left > 0) raw_left--;
    fill++;
    if (fill >= 65535) fill = 0;
  endfunction

  function int clamp(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function void note_request(pswr_pkg::cmd_kind_t kind, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] a);
    longint raw_len;
    longint blocks;
    logic [31:0] idat_len;
    run_bytes.delete();
    if (kind == pswr_pkg::CMD_START) begin
      img_w = clamp(reg_width);
      img_h = clamp(reg_height);
      raw_len = longint'(img_h) * (1 + longint'(img_w) * 4);
      blocks = (raw_len + 65534) / 65535;
      idat_len = 32'(2 + raw_len + blocks * 5 + 4);
      put32(32'h89504E47, 0);
      put32(32'h0D0A1A0A, 0);
      crc = 32'hFFFFFFFF;
      put32(32'd13, 0);
      put32(32'h49484452, 1);
      put32(32'(img_w), 1);
      put32(32'(img_h), 1);
      put(8'd8, 1);
      put(8'd6, 1);
      put(8'd0, 1);
      put(8'd0, 1);
      put(8'd0, 1);
      put_crc();
      put32(idat_len, 0);
      put32(32'h49444154, 1);
      put(8'h78, 1);
      put(8'h01, 1);
      open = 1;
      col = 0;
      row = 0;
      fill = 0;
      raw_left = raw_len;
      ad_lo = 1;
      ad_hi = 0;
    end else if (open) begin
      if (col == 0) put_raw(8'd0);
      put_raw(r);
      put_raw(g);
      put_raw(b);
      put_raw(a);
      col++;
      if (col >= img_w) begin
        col = 0;
        row++;
      end
      if (row >= img_h) begin
        put32({ad_hi[15:0], ad_lo[15:0]}, 1);
        put_crc();
        put32(32'd0, 0);
        put32(32'h49454E44, 1);
        put_crc();
        run_bytes[run_bytes.size()-1].eoi = 1;
        open = 0;
        col = 0;
        row = 0;
        fill = 0;
        raw_left = 0;
        images_done++;
      end
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].last = 1;
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
  endfunction

  function void check_result(logic [7:0] data, logic last, logic eoi);
    png_byte_t e;
    if (expected_bytes.size() == 0) begin
      errors++;
      $display("%0t: unexpected byte %02h last %0b end %0b", $time, data, last, eoi);
      return;
    end
    e = expected_bytes.pop_front();
    if (e.data !== data || e.last !== last || e.eoi !== eoi) begin
      errors++;
      $display("%0t: mismatch expected byte %02h last %0b end %0b, got %02h %0b %0b",
               $time, e.data, e.last, e.eoi, data, last, eoi);
    end
  endfunction
endclass

module tb_png_stored_deflate_writer_top;
  import pswr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        command;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_image;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  png_byte_scoreboard png_sb;
  int send_idle;
  int recv_idle;
  int quiet_cycles;
  int pixels_sent;
  int bytes_seen;
  int rand_items;

  png_stored_deflate_writer_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .empty(empty), .pop(pop), .out_byte(out_byte), .last_of_run(last_of_run),
    .end_of_image(end_of_image), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      png_sb.check_result(out_byte, last_of_run, end_of_image);
      bytes_seen++;
    end
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(cmd_kind_t kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                      logic [7:0] a);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      push = 0;
    end
    @(negedge clk);
    push = 1;
    command = kind;
    red = r;
    green = g;
    blue = b;
    alpha = a;
    @(posedge clk);
    while (full) @(posedge clk);
    png_sb.note_request(kind, r, g, b, a);
    if (kind == CMD_PIXEL) pixels_sent++;
  endtask

  task automatic send_pixel();
    send(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push = 0;
    while (png_sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    png_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic run_image(int w, int h, int pixels);
    write_reg(REG_IMAGE_WIDTH, 13'(w));
    write_reg(REG_IMAGE_HEIGHT, 13'(h));
    send(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < pixels; i++) send_pixel();
  endtask

  task automatic random_images(int target);
    int w;
    int h;
    int n;
    while (rand_items < target) begin
      w = $urandom_range(6, 1);
      h = $urandom_range(4, 1);
      n = w * h;
      if ($urandom_range(99) < 15) n = $urandom_range(n - 1, 0);
      run_image(w, h, n);
      rand_items += n + 1;
      if ($urandom_range(99) < 10) send_pixel();
    end
  endtask

  initial begin
    png_sb = new();
    rst = 1;
    push = 0;
    command = CMD_START;
    red = 0;
    green = 0;
    blue = 0;
    alpha = 0;
    pop = 0;
    cfg_valid = 0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = 0;
    quiet_cycles = 0;
    pixels_sent = 0;
    bytes_seen = 0;
    rand_items = 0;
    send_idle = 34;
    recv_idle = 88;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    send(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'h0000);
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send_pixel();
    send(CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel();
    send_pixel();
    run_image(3, 2, 6);
    run_image(2, 2, 3);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 4; i++) send_pixel();
    random_images(150);

    send_idle = 88;
    recv_idle = 34;
    random_images(290);

    send_idle = 0;
    recv_idle = 0;
    run_image(8191, 1, 3);
    run_image(1, 8191, 3);
    run_image(4096, 5, 3);
    run_image(4096, 4096, 3);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel();

    wait_idle();
    $display("Sent %0d pixels, checked %0d bytes, %0d complete images.",
             pixels_sent, bytes_seen, png_sb.images_done);
    $display("Covered clamped sizes, abandoned images, stray pixels and multi-block headers.");
    if (png_sb.errors == 0 && png_sb.expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
